// ===== hdl/sha1_pkg.sv =====
// Shared constants, types and helper functions for the SHA-1 digest block.
// No dependencies; imported by sha1_message_digest.
`timescale 1ns / 1ps

package sha1_pkg;

    typedef logic [31:0] word_t;

    localparam int NUM_CHAIN  = 5;
    localparam int NUM_SCHED  = 16;
    localparam int NUM_ROUNDS = 80;

    localparam word_t SHA1_IV [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t SHA1_K0 = 32'h5A827999;
    localparam word_t SHA1_K1 = 32'h6ED9EBA1;
    localparam word_t SHA1_K2 = 32'h8F1BBCDC;
    localparam word_t SHA1_K3 = 32'hCA62C1D6;

    localparam word_t PAD_MARKER_WORD = 32'h80000000;

    // Padding progress codes.
    localparam logic [1:0] PAD_NONE   = 2'd0;
    localparam logic [1:0] PAD_FILL   = 2'd1;
    localparam logic [1:0] PAD_LENGTH = 2'd2;
    localparam logic [1:0] PAD_DIGEST = 2'd3;

    function automatic word_t rol1(word_t x);
        return {x[30:0], x[31]};
    endfunction

    function automatic word_t rol5(word_t x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rol30(word_t x);
        return {x[1:0], x[31:2]};
    endfunction

    // Keeps valid leading bytes, then the 0x80 marker; 4+ bytes pass unchanged.
    function automatic word_t last_word(word_t data, logic [2:0] nbytes);
        word_t result;
        case (nbytes)
            3'd0: result = 32'h80000000;
            3'd1: result = {data[31:24], 24'h800000};
            3'd2: result = {data[31:16], 16'h8000};
            3'd3: result = {data[31:8], 8'h80};
            default: result = data;
        endcase
        return result;
    endfunction

endpackage

// ===== hdl/sha1_message_digest.sv =====
// SHA-1 (160-bit) message digest over a stream of big-endian 32-bit words.
// Depends on sha1_pkg for the initial hash words, round constants and helpers.
`timescale 1ns / 1ps

//  Channel   Direction  Ports             Transaction
//  s_axis    in         tdata/tuser/tlast one message word, tlast on the final one
//  m_axis    out        tdata/tlast       one digest word, h0 first, tlast on h4
//
//  A non-final word is taken while idle; every sixteenth word starts the round
//  loop of one shared round unit, then the chaining update. The final word adds
//  one padding word per cycle outside the rounds, and at most one extra block.
//  Reset (aresetn low, synchronous) restores the initial hash words.
//  The digest sits in an output buffer, so the next message may stream in while
//  it drains; a second digest waits until the buffer is empty.

module sha1_message_digest
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_word
    input  logic [2:0]  s_axis_tuser,   // bytes_valid
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic        m_axis_tlast    // digest_last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_ROUND  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  word_idx_reg, word_idx_next;
    logic [6:0]  round_reg, round_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic [1:0]  pad_phase_reg, pad_phase_next;
    logic        marker_reg, marker_next;
    word_t       pad_word_reg, pad_word_next;
    word_t       chain_reg [NUM_CHAIN];
    word_t       chain_next [NUM_CHAIN];
    word_t       work_reg [NUM_CHAIN];
    word_t       work_next [NUM_CHAIN];
    word_t       sched_reg [NUM_SCHED];
    logic        sched_shift;
    word_t       sched_in;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_cnt_reg, out_cnt_next;
    word_t       out_buf_reg [NUM_CHAIN];
    logic        out_load;

    logic        s_fire, m_fire;
    logic [2:0]  nbytes;
    word_t       round_f, round_k, round_t, sched_new;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign nbytes = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_buf_reg[0];
    assign m_axis_tlast  = (out_cnt_reg == 3'd4);

    // Shared round unit: the window always holds W[r] .. W[r+15] at round r.
    always_comb begin
        if (round_reg < 7'd20) begin
            round_f = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            round_k = SHA1_K0;
        end else if (round_reg < 7'd40) begin
            round_f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            round_k = SHA1_K1;
        end else if (round_reg < 7'd60) begin
            round_f = (work_reg[1] & work_reg[2]) | (work_reg[2] & work_reg[3])
                    | (work_reg[1] & work_reg[3]);
            round_k = SHA1_K2;
        end else begin
            round_f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            round_k = SHA1_K3;
        end
        round_t   = rol5(work_reg[0]) + round_f + work_reg[4] + round_k + sched_reg[0];
        sched_new = rol1(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0]);
    end

    always_comb begin
        state_next     = state_reg;
        word_idx_next  = word_idx_reg;
        round_next     = round_reg;
        bit_len_next   = bit_len_reg;
        pad_phase_next = pad_phase_reg;
        marker_next    = marker_reg;
        pad_word_next  = pad_word_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        sched_shift    = 1'b0;
        sched_in       = '0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (!s_axis_tlast) begin
                        bit_len_next = bit_len_reg + 64'd32;
                        sched_shift  = 1'b1;
                        sched_in     = s_axis_tdata;
                    end else begin
                        bit_len_next   = bit_len_reg + {58'd0, nbytes, 3'b000};
                        pad_word_next  = last_word(s_axis_tdata, nbytes);
                        marker_next    = (nbytes == 3'd4);
                        pad_phase_next = PAD_FILL;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sched_shift = 1'b1;
                if (pad_phase_reg == PAD_FILL) begin
                    sched_in      = pad_word_reg;
                    pad_word_next = marker_reg ? PAD_MARKER_WORD : '0;
                    marker_next   = 1'b0;
                    // Zero fill stops once the next free slot is word 14.
                    if (!marker_reg && word_idx_reg == 4'd13) begin
                        pad_phase_next = PAD_LENGTH;
                    end
                end else begin
                    sched_in = (word_idx_reg == 4'd14) ? bit_len_reg[63:32]
                                                       : bit_len_reg[31:0];
                    if (word_idx_reg == 4'd15) begin
                        pad_phase_next = PAD_DIGEST;
                    end
                end
            end
            ST_ROUND: begin
                sched_shift  = 1'b1;
                sched_in     = sched_new;
                work_next[0] = round_t;
                work_next[1] = work_reg[0];
                work_next[2] = rol30(work_reg[1]);
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3];
                round_next   = round_reg + 7'd1;
                if (round_reg == 7'(NUM_ROUNDS - 1)) begin
                    round_next = '0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                for (int i = 0; i < NUM_CHAIN; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (pad_phase_reg == PAD_NONE) begin
                    state_next = ST_IDLE;
                end else if (pad_phase_reg == PAD_DIGEST) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg) begin
                    out_load       = 1'b1;
                    chain_next     = SHA1_IV;
                    bit_len_next   = '0;
                    pad_phase_next = PAD_NONE;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A word pushed into slot 15 completes a block and starts the rounds.
        if (sched_shift && (state_reg == ST_IDLE || state_reg == ST_PAD)) begin
            word_idx_next = word_idx_reg + 4'd1;
            if (word_idx_reg == 4'd15) begin
                work_next  = chain_reg;
                round_next = '0;
                state_next = ST_ROUND;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_cnt_next   = out_cnt_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_cnt_next   = '0;
        end else if (m_fire) begin
            out_cnt_next = out_cnt_reg + 3'd1;
            if (out_cnt_reg == 3'd4) begin
                out_valid_next = 1'b0;
                out_cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            word_idx_reg  <= '0;
            round_reg     <= '0;
            bit_len_reg   <= '0;
            pad_phase_reg <= PAD_NONE;
            marker_reg    <= 1'b0;
            chain_reg     <= SHA1_IV;
            work_reg      <= '{default: '0};
            out_valid_reg <= 1'b0;
            out_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            word_idx_reg  <= word_idx_next;
            round_reg     <= round_next;
            bit_len_reg   <= bit_len_next;
            pad_phase_reg <= pad_phase_next;
            marker_reg    <= marker_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
            out_valid_reg <= out_valid_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    // Payload registers: schedule shift line, pending pad word, digest buffer.
    always_ff @(posedge aclk) begin
        pad_word_reg <= pad_word_next;
        if (sched_shift) begin
            for (int i = 0; i < NUM_SCHED - 1; i++) begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[NUM_SCHED - 1] <= sched_in;
        end
        if (out_load) begin
            out_buf_reg <= chain_reg;
        end else if (m_fire) begin
            for (int i = 0; i < NUM_CHAIN - 1; i++) begin
                out_buf_reg[i] <= out_buf_reg[i + 1];
            end
        end
    end

    // The round counter never passes the last round.
    assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= 7'(NUM_ROUNDS - 1))
        else $error("round counter out of range");

    // No padding is left pending once the block is waiting for input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (pad_phase_reg == PAD_NONE))
        else $error("padding pending while idle");

    // The final block always ends on a block boundary.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (word_idx_reg == 4'd0))
        else $error("digest reached mid-block");

    // The last round is always followed by the chaining update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 7'(NUM_ROUNDS - 1))
        |=> (state_reg == ST_UPDATE))
        else $error("chaining update skipped");

endmodule

// ===== tb/tb_sha1_message_digest.sv =====
// Self-checking testbench for sha1_message_digest: streams messages, predicts each digest.
// Depends on sha1_pkg (word type, initial hash words, round constants) and on the RTL.
`timescale 1ns / 1ps

module tb_sha1_message_digest
    import sha1_pkg::*;
();

    localparam int CYCLE_LIMIT    = 400000;
    localparam int TAIL_CYCLES    = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 300;

    typedef struct packed {
        word_t word;
        logic  last;
    } digest_word_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

    // Tracks the running SHA-1 state of the message stream and the digest words owed.
    class digest_scoreboard;
        word_t          chain [NUM_CHAIN];
        word_t          sched [NUM_SCHED];
        logic [3:0]     widx;
        logic [63:0]    nbits;
        digest_word_t   expected_q [$];
        int             errors;
        int             digests_checked;

        function new();
            restart_message();
            foreach (sched[i]) sched[i] = '0;
            errors = 0;
            digests_checked = 0;
        endfunction

        function void restart_message();
            for (int i = 0; i < NUM_CHAIN; i++) chain[i] = SHA1_IV[i];
            widx = '0;
            nbits = '0;
        endfunction

        function word_t rotl(word_t x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            word_t a, b, c, d, e, w, f, k, t;
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int r = 0; r < NUM_ROUNDS; r++) begin
                if (r >= 16) begin
                    w = sched[(r - 3) & 15] ^ sched[(r - 8) & 15]
                      ^ sched[(r - 14) & 15] ^ sched[r & 15];
                    sched[r & 15] = rotl(w, 1);
                end
                w = sched[r & 15];
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = SHA1_K0;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = SHA1_K1;
                end else if (r < 60) begin
                    f = (b & c) | (c & d) | (b & d);
                    k = SHA1_K2;
                end else begin
                    f = b ^ c ^ d;
                    k = SHA1_K3;
                end
                t = rotl(a, 5) + f + e + k + w;
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void absorb(word_t w);
            sched[widx] = w;
            widx = widx + 1'b1;
            if (widx == 0) compress();
        endfunction

        // Called for every accepted input transaction.
        function void note_input(word_t data, logic [2:0] nbytes, logic last);
            int          nvalid;
            word_t       keep;
            logic [63:0] len;
            digest_word_t item;
            if (!last) begin
                nbits += 64'd32;
                absorb(data);
                return;
            end
            nvalid = (nbytes > 3'd4) ? 4 : int'(nbytes);
            nbits += 64'(nvalid * 8);
            len = nbits;
            if (nvalid == 4) begin
                absorb(data);
                absorb(PAD_MARKER_WORD);
            end else begin
                keep = (nvalid == 0) ? '0 : ('1 << (32 - 8 * nvalid));
                absorb((data & keep) | (PAD_MARKER_WORD >> (8 * nvalid)));
            end
            while (widx != 4'd14) absorb('0);
            absorb(len[63:32]);
            absorb(len[31:0]);
            for (int i = 0; i < NUM_CHAIN; i++) begin
                item.word = chain[i];
                item.last = (i == NUM_CHAIN - 1);
                expected_q = {expected_q, item};
            end
            restart_message();
        endfunction

        // Called for every accepted output transaction.
        function void check_result(word_t data, logic last);
            digest_word_t want;
            if (expected_q.size() == 0) begin
                $error("digest_word %h arrived with no digest pending", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            digests_checked++;
            if (data !== want.word) begin
                $error("digest_word mismatch: expected %h, actual %h", want.word, data);
                errors++;
            end
            if (last !== want.last) begin
                $error("digest_last mismatch: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    digest_scoreboard sb;
    int       cycles = 0;
    int       items_sent = 0;
    int       messages_sent = 0;
    int       burst_left = 0;
    int       hold_requests = 0;
    int       hold_served = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    int       rx_phase = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    sha1_message_digest i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sha1_message_digest verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Receiver: a mode that changes every so often, plus long hold-offs on request.
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
                RX_SLOW:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ((rx_phase % 8) < 5);
            endcase
        end
    end

    // Offers one word and returns at the falling edge after it was taken.
    task automatic send_word(input word_t data, input logic [2:0] nbytes, input logic last);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= nbytes;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_input(data, nbytes, last);
        items_sent++;
        if (last) messages_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    // Random body words (tuser is don't-care on them), then a random final word.
    task automatic send_message(input int nwords);
        word_t tail;
        for (int i = 0; i < nwords; i++) send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
        case ($urandom_range(0, 5))
            0:       tail = '0;
            1:       tail = '1;
            default: tail = $urandom;
        endcase
        send_word(tail, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    task automatic wait_for_digests();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (sb.pending() > 0) @(negedge aclk);
    endtask

    initial begin
        int start_items;
        int nwords;
        int pick;
        sb = new();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty message, the short-message bytes_valid values including
        // out-of-range counts, garbage past the valid bytes and the "abc" string.
        send_word('0, 3'd0, 1'b1);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word('1, 3'd1, 1'b1);
        send_word($urandom, 3'd2, 1'b1);
        send_word('0, 3'd4, 1'b1);
        send_word('1, 3'd5, 1'b1);
        send_word($urandom, 3'd6, 1'b1);
        send_word($urandom, 3'd7, 1'b1);
        // The final word lands at index 14, so the length spills into a second block.
        for (int i = 0; i < 14; i++) send_word((i % 2) ? '1 : $urandom, 3'(i), 1'b0);
        send_word('1, 3'd1, 1'b1);
        wait_for_digests();

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (messages_sent == 12 || messages_sent == 30) begin
                // Long receiver hold-off while short messages keep arriving.
                hold_requests++;
                for (int m = 0; m < 4; m++) send_message($urandom_range(0, 4));
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) nwords = $urandom_range(0, 20);
            else if (pick < 9) nwords = $urandom_range(21, 40);
            else nwords = $urandom_range(41, 70);
            send_message(nwords);
            if ($urandom_range(0, 7) == 0) wait_for_digests();
        end

        wait_for_digests();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d digest words never arrived", sb.pending());
            sb.errors++;
        end

        $display("Covered %0d message words in %0d messages, %0d digest words compared,",
                 items_sent, messages_sent, sb.digests_checked);
        $display("with receiver hold-offs, random stalls and sender bursts and drains.");
        if (sb.errors == 0) begin
            $display("sha1_message_digest verification clean");
        end else begin
            $display("sha1_message_digest verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sha1_pkg.sv
hdl/sha1_message_digest.sv
tb/tb_sha1_message_digest.sv
